### hdl/bounded_array_list_defines.svh
// assertion macros for the bounded array list
// used by bounded_array_list.sv; no other dependencies
`ifndef BOUNDED_ARRAY_LIST_DEFINES_SVH
`define BOUNDED_ARRAY_LIST_DEFINES_SVH
`ifndef SYNTHESIS
`define BAL_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("bounded_array_list: check failed");
`define BAL_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("bounded_array_list: check failed");
`else
`define BAL_ASSERT(lbl, prop)
`define BAL_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### hdl/bal_pkg.sv
// shared types and codes for the bounded array list
// no dependencies
package bal_pkg;

	localparam int CAPACITY_DEF   = 32;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int CAPACITY_MAX   = 256;
	// wide enough for any position or count up to the largest capacity
	localparam int POS_W          = $clog2(CAPACITY_MAX + 1);

	localparam logic [2:0] FN_PUSH_BACK  = 3'd0;
	localparam logic [2:0] FN_PUSH_FRONT = 3'd1;
	localparam logic [2:0] FN_POP_BACK   = 3'd2;
	localparam logic [2:0] FN_POP_FRONT  = 3'd3;
	localparam logic [2:0] FN_REMOVE_AT  = 3'd4;
	localparam logic [2:0] FN_CLEAR      = 3'd5;
	localparam logic [2:0] FN_READ_AT    = 3'd6;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	localparam logic [1:0] CMD_HOLD   = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	typedef struct packed {
		logic [2:0]         func;
		logic signed [31:0] value;
		logic [4:0]         index;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [5:0]         count;
		logic signed [31:0] read_value;
	} out_item_t;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [POS_W-1:0] pos;
	} cell_ctl_t;

endpackage

### hdl/bal_cell.sv
// one storage cell of the list: holds the element at position POS
// depends on bal_pkg
module bal_cell import bal_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int POS        = 0
) (
	input  logic                  clk,
	input  cell_ctl_t             ctl,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic [DATA_WIDTH-1:0] left,
	input  logic [DATA_WIDTH-1:0] right,
	output logic [DATA_WIDTH-1:0] data
);

	localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);

	logic [DATA_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CMD_INSERT: begin
				if (ctl.pos == MY_POS) begin
					data_q <= value;
				end else if (MY_POS > ctl.pos) begin
					data_q <= left;
				end
			end
			CMD_REMOVE: begin
				if (MY_POS >= ctl.pos) begin
					data_q <= right;
				end
			end
			default: begin
			end
		endcase
	end

	assign data = data_q;

endmodule

### hdl/bounded_array_list.sv
// bounded array list top level: control, cell row and result register
// depends on bal_pkg, bal_cell and bounded_array_list_defines.svh
//
// An ordered list of up to CAPACITY signed elements held in a row of
// register cells, one element per cell. Each input item on in_data carries
// an operation (push back/front, pop back/front, remove at, clear, read at),
// a value and an index; each item yields exactly one result on out_data with
// a status, the count after the operation and the element read.
// Both channels use valid/ready. An item is taken when in_valid and
// in_ready are high; its registered result shows on out_data the next cycle.
// Inserts and removes move every cell in that same cycle, so the block
// takes one item per cycle; the only limit is the single result register,
// so in_ready drops only while a result waits and out_ready is low.
// After reset the list is empty and no result is pending; cell contents
// are undefined until pushed. A stalled receiver holds the result and
// the list state until it takes the result.
`include "bounded_array_list_defines.svh"
module bounded_array_list import bal_pkg::*; #(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_nx;
	logic                  out_valid_q;
	out_item_t             out_q;
	logic                  in_acc;
	logic [POS_W-1:0]      count_w;
	logic [POS_W-1:0]      idx_w;
	logic                  full;
	logic                  empty;
	logic                  in_range;
	logic [1:0]            status;
	logic                  read_ok;
	cell_ctl_t             ctl;
	cell_ctl_t             ctl_req;
	logic signed [63:0]    val_ext;
	logic [DATA_WIDTH-1:0] elem_in;
	logic signed [DATA_WIDTH-1:0] rd_elem;
	logic signed [63:0]    rd_ext;
	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];

	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;

	assign count_w  = POS_W'(count_q);
	assign idx_w    = POS_W'(in_data.index);
	assign full     = (count_w == POS_W'(CAPACITY));
	assign empty    = (count_q == '0);
	assign in_range = (idx_w < count_w);

	assign val_ext = 64'(in_data.value);
	assign elem_in = val_ext[DATA_WIDTH-1:0];

	always_comb begin
		status      = ST_OK;
		count_nx    = count_q;
		read_ok     = 1'b0;
		ctl_req.cmd = CMD_HOLD;
		ctl_req.pos = '0;
		unique case (in_data.func)
			FN_PUSH_BACK: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					// insert at the end: nothing above it is valid
					ctl_req.cmd = CMD_INSERT;
					ctl_req.pos = count_w;
					count_nx    = CW'(count_q + 1'b1);
				end
			end
			FN_PUSH_FRONT: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					ctl_req.cmd = CMD_INSERT;
					count_nx    = CW'(count_q + 1'b1);
				end
			end
			FN_POP_BACK: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					count_nx = CW'(count_q - 1'b1);
				end
			end
			FN_POP_FRONT: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					ctl_req.cmd = CMD_REMOVE;
					count_nx    = CW'(count_q - 1'b1);
				end
			end
			FN_REMOVE_AT: begin
				if (!in_range) begin
					status = ST_RANGE;
				end else begin
					ctl_req.cmd = CMD_REMOVE;
					ctl_req.pos = idx_w;
					count_nx    = CW'(count_q - 1'b1);
				end
			end
			FN_CLEAR: begin
				count_nx = '0;
			end
			FN_READ_AT: begin
				if (!in_range) begin
					status = ST_RANGE;
				end else begin
					read_ok = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		ctl = ctl_req;
		if (!in_acc) begin
			ctl.cmd = CMD_HOLD;
		end
	end

	// read select: and-or over the row
	always_comb begin
		rd_elem = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (idx_w == POS_W'(i)) begin
				rd_elem = rd_elem | cell_data[i];
			end
		end
	end

	assign rd_ext = 64'(rd_elem);

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [DATA_WIDTH-1:0] left;
		logic [DATA_WIDTH-1:0] right;
		if (g == 0) begin : g_first
			assign left = cell_data[g];
		end else begin : g_mid
			assign left = cell_data[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right = cell_data[g];
		end else begin : g_inner
			assign right = cell_data[g+1];
		end
		bal_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.POS       (g)
		) u_cell (
			.clk  (clk),
			.ctl  (ctl),
			.value(elem_in),
			.left (left),
			.right(right),
			.data (cell_data[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				count_q     <= count_nx;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_q.status     <= status;
			out_q.count      <= 6'(count_nx);
			out_q.read_value <= read_ok ? rd_ext[31:0] : 32'sd0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`BAL_ASSERT(a_count_bounded, count_q <= CW'(CAPACITY))
	`BAL_ASSERT(a_result_follows, in_acc |=> out_valid_q)
	`BAL_ASSERT(a_refused_keeps_count, in_acc && status != ST_OK |=> $stable(count_q))
	`BAL_ASSERT(a_push_grows, ctl.cmd == CMD_INSERT |=> count_q == CW'($past(count_q) + 1'b1))
	`BAL_ASSERT(a_read_zero_on_fail, out_valid_q && out_q.status != ST_OK |-> out_q.read_value == 32'sd0)
	`BAL_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !out_valid_q && count_q == '0)

endmodule

### dv/testbench.sv
// testbench for bounded_array_list: a directed table of list operations, then
// shaped random fill, drain and mixed sequences checked against a local model
// depends on bal_pkg and the bounded_array_list rtl
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import bal_pkg::*;

	localparam int         LIST_CAP    = CAPACITY_DEF;
	localparam int         HOLD_CYCLES = 80;
	localparam logic [2:0] FN_UNUSED   = 3'd7;

	typedef enum {SEQ_FILL, SEQ_DRAIN, SEQ_MIXED} seq_mode_t;

	typedef struct {
		in_item_t  op;
		bit        typed;
		out_item_t want;
	} plan_row_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	bounded_array_list u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// list contents as the block should hold them
	logic signed [31:0] list_store [LIST_CAP];
	int                 list_count;

	out_item_t  pending_results [$];
	int         error_count;
	int         send_idle_pct;
	int         recv_stall_pct;
	bit         hold_req;
	int         hold_left;
	bit         row_typed;
	out_item_t  row_want;
	seq_mode_t  seq_mode;

	plan_row_t seed_plan [23] = '{
		'{'{FN_READ_AT,    32'sh00000000, 5'd0},  1'b1, '{ST_RANGE, 6'd0, 32'sh00000000}},
		'{'{FN_POP_BACK,   32'sh00000000, 5'd0},  1'b1, '{ST_EMPTY, 6'd0, 32'sh00000000}},
		'{'{FN_POP_FRONT,  32'sh00000000, 5'd0},  1'b1, '{ST_EMPTY, 6'd0, 32'sh00000000}},
		'{'{FN_REMOVE_AT,  32'sh00000000, 5'd31}, 1'b1, '{ST_RANGE, 6'd0, 32'sh00000000}},
		'{'{FN_PUSH_BACK,  32'sh7fffffff, 5'd0},  1'b1, '{ST_OK,    6'd1, 32'sh00000000}},
		'{'{FN_PUSH_FRONT, 32'sh80000000, 5'd31}, 1'b1, '{ST_OK,    6'd2, 32'sh00000000}},
		'{'{FN_READ_AT,    32'sh00000000, 5'd0},  1'b1, '{ST_OK,    6'd2, 32'sh80000000}},
		'{'{FN_READ_AT,    32'sh00000000, 5'd1},  1'b1, '{ST_OK,    6'd2, 32'sh7fffffff}},
		'{'{FN_READ_AT,    32'sh00000000, 5'd2},  1'b1, '{ST_RANGE, 6'd2, 32'sh00000000}},
		'{'{FN_PUSH_BACK,  32'shffffffff, 5'd0},  1'b1, '{ST_OK,    6'd3, 32'sh00000000}},
		'{'{FN_PUSH_FRONT, 32'sh00000000, 5'd0},  1'b0, '{ST_OK,    6'd0, 32'sh00000000}},
		'{'{FN_PUSH_BACK,  32'sh5a5aa5a5, 5'd0},  1'b0, '{ST_OK,    6'd0, 32'sh00000000}},
		'{'{FN_READ_AT,    32'shffffffff, 5'd31}, 1'b1, '{ST_RANGE, 6'd5, 32'sh00000000}},
		'{'{FN_REMOVE_AT,  32'sh00000000, 5'd2},  1'b0, '{ST_OK,    6'd0, 32'sh00000000}},
		'{'{FN_READ_AT,    32'sh00000000, 5'd2},  1'b0, '{ST_OK,    6'd0, 32'sh00000000}},
		'{'{FN_REMOVE_AT,  32'sh00000000, 5'd3},  1'b0, '{ST_OK,    6'd0, 32'sh00000000}},
		'{'{FN_UNUSED,     32'shffffffff, 5'd31}, 1'b1, '{ST_OK,    6'd3, 32'sh00000000}},
		'{'{FN_POP_BACK,   32'sh00000000, 5'd0},  1'b0, '{ST_OK,    6'd0, 32'sh00000000}},
		'{'{FN_POP_FRONT,  32'sh00000000, 5'd0},  1'b0, '{ST_OK,    6'd0, 32'sh00000000}},
		'{'{FN_READ_AT,    32'sh00000000, 5'd0},  1'b0, '{ST_OK,    6'd0, 32'sh00000000}},
		'{'{FN_CLEAR,      32'sh00000000, 5'd0},  1'b1, '{ST_OK,    6'd0, 32'sh00000000}},
		'{'{FN_CLEAR,      32'shffffffff, 5'd31}, 1'b1, '{ST_OK,    6'd0, 32'sh00000000}},
		'{'{FN_READ_AT,    32'sh00000000, 5'd0},  1'b1, '{ST_RANGE, 6'd0, 32'sh00000000}}
	};

	function automatic out_item_t list_apply(in_item_t op);
		out_item_t res;
		int        i;
		int        pos;
		res = '{ST_OK, 6'd0, 32'sh00000000};
		case (op.func)
			FN_PUSH_BACK, FN_PUSH_FRONT: begin
				if (list_count >= LIST_CAP) begin
					res.status = ST_FULL;
				end else begin
					if (op.func == FN_PUSH_BACK) begin
						list_store[list_count] = op.value;
					end else begin
						for (i = list_count; i > 0; i--)
							list_store[i] = list_store[i - 1];
						list_store[0] = op.value;
					end
					list_count++;
				end
			end
			FN_POP_BACK: begin
				if (list_count == 0)
					res.status = ST_EMPTY;
				else
					list_count--;
			end
			FN_POP_FRONT, FN_REMOVE_AT: begin
				pos = (op.func == FN_POP_FRONT) ? 0 : int'(op.index);
				if (op.func == FN_POP_FRONT && list_count == 0) begin
					res.status = ST_EMPTY;
				end else if (pos >= list_count) begin
					res.status = ST_RANGE;
				end else begin
					for (i = pos; i + 1 < list_count; i++)
						list_store[i] = list_store[i + 1];
					list_count--;
				end
			end
			FN_CLEAR: begin
				list_count = 0;
			end
			FN_READ_AT: begin
				if (int'(op.index) >= list_count)
					res.status = ST_RANGE;
				else
					res.read_value = list_store[op.index];
			end
			default: ;
		endcase
		res.count = list_count[5:0];
		return res;
	endfunction

	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'sh00000000;
			1: return 32'shffffffff;
			2: return 32'sh7fffffff;
			3: return 32'sh80000000;
			default: return $urandom();
		endcase
	endfunction

	// mostly a held position, otherwise anywhere in the index field
	function automatic logic [4:0] pick_index(bit held);
		if (held && list_count > 0)
			return 5'($urandom_range(0, list_count - 1));
		return 5'($urandom_range(0, 31));
	endfunction

	function automatic in_item_t next_op(seq_mode_t mode);
		in_item_t op;
		int       r;
		op.value = pick_word();
		op.index = pick_index(1'b1);
		r = $urandom_range(0, 99);
		// a little noise in every sequence
		if ($urandom_range(0, 99) < 5) begin
			op.func  = 3'($urandom_range(0, 7));
			op.index = pick_index(1'b0);
			return op;
		end
		case (mode)
			SEQ_FILL: begin
				if (r < 45)      op.func = FN_PUSH_BACK;
				else if (r < 85) op.func = FN_PUSH_FRONT;
				else if (r < 95) op.func = FN_READ_AT;
				else if (r < 98) op.func = FN_REMOVE_AT;
				else             op.func = FN_POP_BACK;
			end
			SEQ_DRAIN: begin
				if (r < 30)      op.func = FN_POP_BACK;
				else if (r < 60) op.func = FN_POP_FRONT;
				else if (r < 85) op.func = FN_REMOVE_AT;
				else if (r < 97) op.func = FN_READ_AT;
				else             op.func = FN_CLEAR;
			end
			default: begin
				if (r < 3)      op.func = FN_UNUSED;
				else if (r < 6) op.func = FN_CLEAR;
				else begin
					case ($urandom_range(0, 5))
						0: op.func = FN_PUSH_BACK;
						1: op.func = FN_PUSH_FRONT;
						2: op.func = FN_POP_BACK;
						3: op.func = FN_POP_FRONT;
						4: op.func = FN_REMOVE_AT;
						default: op.func = FN_READ_AT;
					endcase
				end
				if ($urandom_range(0, 1) == 0)
					op.index = pick_index(1'b0);
			end
		endcase
		return op;
	endfunction

	// called and returns at a falling edge
	task automatic offer(in_item_t op, bit typed, out_item_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid  = 1'b1;
		in_data   = op;
		row_typed = typed;
		row_want  = want;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic set_idling(int send_pct, int recv_pct);
		@(posedge clk);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		@(negedge clk);
	endtask

	task automatic hold_receiver();
		@(posedge clk);
		hold_req = 1'b1;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_random(int n);
		int       left;
		int       seq_len;
		int       k;
		in_item_t op;
		left = n;
		while (left > 0) begin
			seq_len = (seq_mode == SEQ_MIXED) ? 30 : 45;
			k = 0;
			while (k < seq_len && left > 0) begin
				op = next_op(seq_mode);
				offer(op, 1'b0, '0);
				if (op.func != FN_UNUSED)
					left--;
				k++;
			end
			case (seq_mode)
				SEQ_FILL:  seq_mode = SEQ_DRAIN;
				SEQ_DRAIN: seq_mode = SEQ_MIXED;
				default:   seq_mode = SEQ_FILL;
			endcase
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else begin
			out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : result_check
		out_item_t got;
		out_item_t want;
		out_item_t pred;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = out_data;
				if (pending_results.size() == 0) begin
					$error("result with no item outstanding: status %0d count %0d",
						got.status, got.count);
					error_count++;
				end else begin
					want = pending_results.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						error_count++;
					end
					if (got.count !== want.count) begin
						$error("count: expected %0d, got %0d", want.count, got.count);
						error_count++;
					end
					if (got.read_value !== want.read_value) begin
						$error("read_value: expected %0d, got %0d",
							want.read_value, got.read_value);
						error_count++;
					end
				end
			end
			// model state moves with every accepted item, typed rows included
			if (in_valid && in_ready) begin
				pred = list_apply(in_data);
				pending_results.push_back(row_typed ? row_want : pred);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("bounded_array_list regression: fail");
		$finish;
	end

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_data        = '0;
		out_ready      = 1'b0;
		row_typed      = 1'b0;
		row_want       = '0;
		hold_req       = 1'b0;
		hold_left      = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		error_count    = 0;
		list_count     = 0;
		seq_mode       = SEQ_FILL;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (seed_plan[i])
			offer(seed_plan[i].op, seed_plan[i].typed, seed_plan[i].want);
		wait_drained();

		// receiver held off while items keep coming, so the input stalls
		hold_receiver();
		run_random(200);
		set_idling(72, 0);
		run_random(200);
		// sender pauses until the list has answered everything
		wait_drained();
		set_idling(0, 72);
		run_random(200);
		set_idling(31, 31);
		run_random(200);

		wait_drained();
		repeat (5) @(negedge clk);
		if (error_count == 0)
			$display("bounded_array_list regression: pass");
		else
			$display("bounded_array_list regression: fail");
		$finish;
	end

endmodule
